FILE: hdl/tsq_pkg.sv
package tsq_pkg;

    // field widths
    localparam int SAMPLE_W   = 12;
    localparam int POS_W      = 16;
    localparam int SCALE_W    = 19;
    localparam int LIMIT_W    = 12;
    localparam int FRAC_W     = 16;
    localparam int ALU_W      = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // default filter geometry
    localparam int SAMPLES_DEFAULT = 5;
    localparam int DROP_DEFAULT    = 1;

    localparam logic [POS_W-1:0]   IDLE_POS     = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] AGREE_RESET  = 12'd50;

    // request kinds on the input stream
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_PEN_UP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AGREE_LIMIT = 3'd4;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic signed [SCALE_W-1:0] x_scale;
        logic signed [POS_W-1:0]   x_offset;
        logic signed [SCALE_W-1:0] y_scale;
        logic signed [POS_W-1:0]   y_offset;
        logic [LIMIT_W-1:0]        agree_limit;
    } t_cfg;

    typedef struct packed {
        logic             pressed;
        logic             caught;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] first_x;
        logic [POS_W-1:0] first_y;
        logic             read_ok;
    } t_res;

endpackage

FILE: hdl/tsq_alu.sv
module tsq_alu (
    input  tsq_pkg::t_alu_op            i_op,
    input  logic [tsq_pkg::ALU_W-1:0]   i_a,
    input  logic [tsq_pkg::ALU_W-1:0]   i_b,
    output logic [tsq_pkg::ALU_W-1:0]   o_res,
    output logic                        o_carry
);

    logic [tsq_pkg::ALU_W:0] wide;

    // shared add/subtract; carry out of subtract is the borrow (a < b)
    always_comb begin
        unique case (i_op)
            tsq_pkg::ALU_ADD: wide = {1'b0, i_a} + {1'b0, i_b};
            tsq_pkg::ALU_SUB: wide = {1'b0, i_a} - {1'b0, i_b};
            default:          wide = '0;
        endcase
    end

    assign o_res   = wide[tsq_pkg::ALU_W-1:0];
    assign o_carry = wide[tsq_pkg::ALU_W];

endmodule

FILE: hdl/tsq_core.sv
module tsq_core #(
    parameter int SAMPLES_PER_READ = tsq_pkg::SAMPLES_DEFAULT,
    parameter int DROP_EACH_END    = tsq_pkg::DROP_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic [tsq_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_raw_mode,
    input  tsq_pkg::t_cfg                   i_cfg,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output tsq_pkg::t_res                   o_res
);

    localparam int N      = SAMPLES_PER_READ;
    localparam int DE     = (2 * DROP_EACH_END >= N) ? (N - 1) / 2 : DROP_EACH_END;
    localparam int K      = N - 2 * DE;
    localparam int LAST   = N - DE - 1;
    localparam int IDX_W  = $clog2(N);
    localparam int SUM_W  = $clog2(K * (2 ** tsq_pkg::SAMPLE_W - 1) + 1);
    localparam int PROD_W = tsq_pkg::SCALE_W + tsq_pkg::SAMPLE_W + 1;
    localparam int SW     = tsq_pkg::SAMPLE_W;
    localparam int AW     = tsq_pkg::ALU_W;
    localparam int PW     = tsq_pkg::POS_W;

    // sum / K as (sum * ceil(2^DIV_SH / K)) >> DIV_SH, exact for every SUM_W-bit sum
    localparam int DIV_SH  = SUM_W + $clog2(K);
    localparam int RECIP_W = SUM_W + 1;
    localparam int DPROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** DIV_SH + K - 1) / K);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_INS  = 11'b000_0000_0010,
        S_SUM  = 11'b000_0000_0100,
        S_DIV  = 11'b000_0000_1000,
        S_AD1  = 11'b000_0001_0000,
        S_AD2  = 11'b000_0010_0000,
        S_AD3  = 11'b000_0100_0000,
        S_AVG  = 11'b000_1000_0000,
        S_MUL  = 11'b001_0000_0000,
        S_OFF  = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [1:0]        r_grp, n_grp;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SW-1:0]     r_sample, n_sample;
    logic              r_raw, n_raw;
    logic              r_last, n_last;
    logic [SW-1:0]     r_srt [N];
    logic [SW-1:0]     n_srt [N];
    logic [AW-1:0]     r_acc, n_acc;
    logic [SW-1:0]     r_mean [4];
    logic [SW-1:0]     n_mean [4];
    logic              r_ax, n_ax;
    logic              r_ok, n_ok;
    logic [SW-1:0]     r_avg, n_avg;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [PW-1:0]     r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [PW-1:0]     r_press_x, n_press_x, r_press_y, n_press_y;
    logic              r_held, n_held, r_caught, n_caught;
    logic              r_penup, n_penup;

    // shared unit hookup
    tsq_pkg::t_alu_op  alu_op;
    logic [AW-1:0]     alu_a, alu_b, alu_res;
    logic              alu_carry;

    logic [SW-1:0]     srt_rd;
    logic [IDX_W-1:0]  idx_up;
    logic [SW-1:0]     mean_a, mean_b;
    logic signed [tsq_pkg::SCALE_W-1:0] scale_sel;
    logic [PW-1:0]     off_sel;
    logic signed [PROD_W-1:0] mul_res;
    logic [DPROD_W-1:0] div_prod;
    logic [SW-1:0]     quo;
    logic [SW-1:0]     avg_new;
    logic              in_acc;

    // values that the finishing step leaves behind
    logic              f_held, f_caught;
    logic [PW-1:0]     f_cur_x, f_cur_y, f_press_x, f_press_y;

    tsq_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign srt_rd     = r_srt[r_idx];
    assign idx_up     = r_idx + IDX_W'(1);
    assign mean_a     = r_ax ? r_mean[1] : r_mean[0];
    assign mean_b     = r_ax ? r_mean[3] : r_mean[2];
    assign scale_sel  = r_ax ? i_cfg.y_scale : i_cfg.x_scale;
    assign off_sel    = r_ax ? i_cfg.y_offset : i_cfg.x_offset;
    assign mul_res    = scale_sel * $signed({1'b0, r_avg});
    assign div_prod   = DPROD_W'(r_acc[SUM_W-1:0]) * DPROD_W'(RECIP);
    assign quo        = div_prod[DIV_SH +: SW];
    assign avg_new    = alu_res[SW:1];

    // operand select for the shared unit
    always_comb begin
        alu_op = tsq_pkg::ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_INS: begin
                alu_a = AW'(r_sample);
                alu_b = AW'(srt_rd);
            end
            S_SUM: begin
                alu_op = tsq_pkg::ALU_ADD;
                alu_a  = r_acc;
                alu_b  = AW'(srt_rd);
            end
            S_AD1: begin
                alu_a = AW'(mean_a);
                alu_b = AW'(mean_b);
            end
            S_AD2: begin
                alu_a = AW'(mean_b);
                alu_b = AW'(mean_a);
            end
            S_AD3: begin
                alu_a = r_acc;
                alu_b = AW'(i_cfg.agree_limit);
            end
            S_AVG: begin
                alu_op = tsq_pkg::ALU_ADD;
                alu_a  = AW'(mean_a);
                alu_b  = AW'(mean_b);
            end
            S_OFF: begin
                alu_op = tsq_pkg::ALU_ADD;
                alu_a  = AW'(r_prod[PROD_W-1:tsq_pkg::FRAC_W]);
                alu_b  = AW'(off_sel);
            end
            default: begin
                alu_op = tsq_pkg::ALU_SUB;
            end
        endcase
    end

    // press/idle bookkeeping at result time
    always_comb begin
        f_held    = r_held;
        f_caught  = r_caught;
        f_cur_x   = r_cur_x;
        f_cur_y   = r_cur_y;
        f_press_x = r_press_x;
        f_press_y = r_press_y;
        if (r_penup) begin
            if (r_held) begin
                f_held = 1'b0;
            end else begin
                f_press_x = '0;
                f_press_y = '0;
                f_cur_x   = tsq_pkg::IDLE_POS;
                f_cur_y   = tsq_pkg::IDLE_POS;
            end
        end else begin
            f_held = 1'b1;
            if (!r_held) begin
                f_caught  = 1'b1;
                f_press_x = r_cur_x;
                f_press_y = r_cur_y;
            end
        end
    end

    assign o_res_valid   = (r_state == S_FIN);
    assign o_res.pressed = f_held;
    assign o_res.caught  = f_caught;
    assign o_res.pos_x   = f_cur_x;
    assign o_res.pos_y   = f_cur_y;
    assign o_res.first_x = f_press_x;
    assign o_res.first_y = f_press_y;
    assign o_res.read_ok = r_ok && !r_penup;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_grp     = r_grp;
        n_idx     = r_idx;
        n_sample  = r_sample;
        n_raw     = r_raw;
        n_last    = r_last;
        n_srt     = r_srt;
        n_acc     = r_acc;
        n_mean    = r_mean;
        n_ax      = r_ax;
        n_ok      = r_ok;
        n_avg     = r_avg;
        n_prod    = r_prod;
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_press_x = r_press_x;
        n_press_y = r_press_y;
        n_held    = r_held;
        n_caught  = r_caught;
        n_penup   = r_penup;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_mode)
                        tsq_pkg::MODE_SAMPLE: begin
                            n_sample = i_sample;
                            n_raw    = i_raw_mode;
                            n_last   = (r_slot == IDX_W'(N - 1));
                            n_slot   = (r_slot == IDX_W'(N - 1)) ? '0 : r_slot + IDX_W'(1);
                            if (r_slot == '0) begin
                                n_srt[0] = i_sample;
                            end else begin
                                n_idx   = r_slot - IDX_W'(1);
                                n_state = S_INS;
                            end
                        end
                        tsq_pkg::MODE_PEN_UP: begin
                            n_slot  = '0;
                            n_grp   = '0;
                            n_penup = 1'b1;
                            n_state = S_FIN;
                        end
                        tsq_pkg::MODE_CLEAR: begin
                            n_caught = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            // insertion step: shift the larger entry up or drop the sample in
            S_INS: begin
                if (alu_carry) begin
                    n_srt[idx_up] = srt_rd;
                    if (r_idx == '0) begin
                        n_srt[0] = r_sample;
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end else begin
                    n_srt[idx_up] = r_sample;
                end
                if (!alu_carry || r_idx == '0) begin
                    if (r_last) begin
                        n_acc   = '0;
                        n_idx   = IDX_W'(DE);
                        n_state = S_SUM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            // sum of the kept middle entries
            S_SUM: begin
                n_acc = alu_res;
                if (r_idx == IDX_W'(LAST)) begin
                    n_state = S_DIV;
                end else begin
                    n_idx = idx_up;
                end
            end
            // mean of the kept entries: multiply by the reciprocal of the kept count
            S_DIV: begin
                n_mean[r_grp] = quo;
                if (r_grp == 2'd3) begin
                    n_grp   = '0;
                    n_ok    = 1'b1;
                    n_ax    = 1'b0;
                    n_penup = 1'b0;
                    n_state = S_AD1;
                end else begin
                    n_grp   = r_grp + 2'd1;
                    n_state = S_IDLE;
                end
            end
            // per-axis agreement: |a - b| < limit
            S_AD1: begin
                n_acc   = alu_res;
                n_state = alu_carry ? S_AD2 : S_AD3;
            end
            S_AD2: begin
                n_acc   = alu_res;
                n_state = S_AD3;
            end
            S_AD3: begin
                if (!alu_carry) begin
                    n_ok = 1'b0;
                end
                if (!r_ax) begin
                    n_ax    = 1'b1;
                    n_state = S_AD1;
                end else begin
                    n_ax    = 1'b0;
                    n_state = (r_ok && alu_carry) ? S_AVG : S_FIN;
                end
            end
            // averaged reading, then optional screen mapping
            S_AVG: begin
                if (r_raw) begin
                    if (r_ax) begin
                        n_cur_y = PW'(avg_new);
                        n_ax    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_cur_x = PW'(avg_new);
                        n_ax    = 1'b1;
                    end
                end else begin
                    n_avg   = avg_new;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = mul_res;
                n_state = S_OFF;
            end
            S_OFF: begin
                if (r_ax) begin
                    n_cur_y = alu_res[PW-1:0];
                    n_ax    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_cur_x = alu_res[PW-1:0];
                    n_ax    = 1'b1;
                    n_state = S_AVG;
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    n_held    = f_held;
                    n_caught  = f_caught;
                    n_cur_x   = f_cur_x;
                    n_cur_y   = f_cur_y;
                    n_press_x = f_press_x;
                    n_press_y = f_press_y;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_slot    <= '0;
            r_grp     <= '0;
            r_ax      <= 1'b0;
            r_ok      <= 1'b0;
            r_penup   <= 1'b0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_press_x <= '0;
            r_press_y <= '0;
            r_held    <= 1'b0;
            r_caught  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_grp     <= n_grp;
            r_ax      <= n_ax;
            r_ok      <= n_ok;
            r_penup   <= n_penup;
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_press_x <= n_press_x;
            r_press_y <= n_press_y;
            r_held    <= n_held;
            r_caught  <= n_caught;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_sample <= n_sample;
        r_raw    <= n_raw;
        r_last   <= n_last;
        r_srt    <= n_srt;
        r_acc    <= n_acc;
        r_mean   <= n_mean;
        r_avg    <= n_avg;
        r_prod   <= n_prod;
    end

endmodule

FILE: hdl/touch_sample_qualifier.sv
// A sample that opens a group is stored directly; any other sample is inserted into the sorted group
// (insertion into the sorted group, one compare per cycle on the shared adder).
// Closing a group adds a sum over the kept entries and a divide step (reciprocal multiply).
// Closing a scan: agreement check on both axes, then raw averaging or scaled mapping when both agree, then output.
// One request at a time: a new request is taken only once the last one is done; a pen-up goes straight to output.
// Reset (sync, active low) clears flags, positions and counters; agree_limit resets to 50.
module touch_sample_qualifier #(
    parameter int SAMPLES_PER_READ = tsq_pkg::SAMPLES_DEFAULT,
    parameter int DROP_EACH_END    = tsq_pkg::DROP_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [11:0] sample
    input  logic [2:0]                        s_axis_tuser,  // [1:0] mode, [2] raw_mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // pos_x, pos_y, first_x, first_y
    output logic [2:0]                        m_axis_tuser,  // pressed, caught, read_ok
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tsq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tsq_pkg::t_cfg r_cfg;
    tsq_pkg::t_res core_res, r_out;
    logic          core_res_valid, res_ready;
    logic          r_out_valid;

    // register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_scale     <= '0;
            r_cfg.x_offset    <= '0;
            r_cfg.y_scale     <= '0;
            r_cfg.y_offset    <= '0;
            r_cfg.agree_limit <= tsq_pkg::AGREE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tsq_pkg::REG_X_SCALE:
                    r_cfg.x_scale <= $signed(i_cfg_data[tsq_pkg::SCALE_W-1:0]);
                tsq_pkg::REG_X_OFFSET:
                    r_cfg.x_offset <= $signed(i_cfg_data[tsq_pkg::POS_W-1:0]);
                tsq_pkg::REG_Y_SCALE:
                    r_cfg.y_scale <= $signed(i_cfg_data[tsq_pkg::SCALE_W-1:0]);
                tsq_pkg::REG_Y_OFFSET:
                    r_cfg.y_offset <= $signed(i_cfg_data[tsq_pkg::POS_W-1:0]);
                tsq_pkg::REG_AGREE_LIMIT:
                    r_cfg.agree_limit <= i_cfg_data[tsq_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tsq_core #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ),
        .DROP_EACH_END    (DROP_EACH_END)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser[1:0]),
        .i_sample    (s_axis_tdata[tsq_pkg::SAMPLE_W-1:0]),
        .i_raw_mode  (s_axis_tuser[2]),
        .i_cfg       (r_cfg),
        .o_res_valid (core_res_valid),
        .i_res_ready (res_ready),
        .o_res       (core_res)
    );

    // output register: takes a new result as the old one leaves
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid && res_ready) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.first_y, r_out.first_x, r_out.pos_y, r_out.pos_x};
    assign m_axis_tuser  = {r_out.read_ok, r_out.caught, r_out.pressed};

endmodule

FILE: hdl/tsq_checker.sv
module tsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // an agreeing reading always comes with the pen held
    a_ok_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0])
        else $error("read_ok without pressed");

    // a pen-up request produces a result, so the block stops taking requests
    a_penup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser[1:0] == tsq_pkg::MODE_PEN_UP |=> !s_axis_tready)
        else $error("still ready after pen-up request");

    // a clear request does not make the block busy
    a_clear_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser[1:0] == tsq_pkg::MODE_CLEAR |=> s_axis_tready)
        else $error("busy after clear request");

endmodule

bind touch_sample_qualifier tsq_checker u_tsq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_touch_sample_qualifier.sv
module tb_touch_sample_qualifier;
    import tsq_pkg::*;

    // filter geometry, same defaults as the block
    localparam int SPR      = SAMPLES_DEFAULT;
    localparam int DROP     = (2 * DROP_DEFAULT >= SPR) ? (SPR - 1) / 2 : DROP_DEFAULT;
    localparam int KEPT     = SPR - 2 * DROP;
    localparam int SCAN_LEN = 4 * SPR;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // cycles to let the block finish a group it closed without a report
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;  // [11:0] sample
    logic [2:0]            s_axis_tuser  = '0;  // [1:0] mode, [2] raw_mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [63:0]           m_axis_tdata;        // pos_x, pos_y, first_x, first_y
    logic [2:0]            m_axis_tuser;        // pressed, caught, read_ok
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    touch_sample_qualifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the filter state and registers
    t_cfg        cfg_shadow;
    logic [11:0] grp_samples [SPR];
    int          grp_means [3];
    int          scan_pos;
    logic [15:0] cur_x, cur_y, first_x, first_y;
    logic        held, caught;

    t_res pending_reports [$];
    int   items_sent    = 0;
    int   fault_count   = 0;
    int   idle_cycles   = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    function automatic int trimmed_mean();
        int v [SPR];
        int t, sum;
        sum = 0;
        for (int i = 0; i < SPR; i++) v[i] = grp_samples[i];
        for (int i = 0; i + 1 < SPR; i++)
            for (int j = i + 1; j < SPR; j++)
                if (v[i] > v[j]) begin
                    t = v[i]; v[i] = v[j]; v[j] = t;
                end
        for (int i = DROP; i < SPR - DROP; i++) sum += v[i];
        return sum / KEPT;
    endfunction

    function automatic logic axis_close(input int a, input int b);
        int d;
        d = (a > b) ? a - b : b - a;
        return d < int'(cfg_shadow.agree_limit);
    endfunction

    // Q3.16 scale plus offset, floored, wrapped to 16 bits
    function automatic logic [15:0] to_screen(input int raw, input logic signed [18:0] sc,
                                              input logic signed [15:0] off);
        longint v;
        v = longint'(sc) * longint'(raw) + longint'(off) * 65536;
        return v[31:16];
    endfunction

    function automatic t_res snapshot(input logic ok);
        t_res r;
        r.pressed = held;
        r.caught  = caught;
        r.pos_x   = cur_x;
        r.pos_y   = cur_y;
        r.first_x = first_x;
        r.first_y = first_y;
        r.read_ok = ok;
        return r;
    endfunction

    function automatic string fmt_res(input t_res r);
        return $sformatf("pressed=%0d caught=%0d pos=%h,%h first=%h,%h ok=%0d",
                         r.pressed, r.caught, r.pos_x, r.pos_y, r.first_x, r.first_y,
                         r.read_ok);
    endfunction

    // advance the shadow by one accepted request, queue the report it causes
    task automatic track_request(input logic [1:0] mode, input logic [11:0] smp,
                                 input logic raw);
        int   slot, grp, x1, y1, x2, y2;
        logic ok;
        case (mode)
            MODE_SAMPLE: begin
                slot = scan_pos % SPR;
                grp  = scan_pos / SPR;
                grp_samples[slot] = smp;
                scan_pos++;
                if (slot == SPR - 1) begin
                    if (grp < 3) begin
                        grp_means[grp] = trimmed_mean();
                    end else begin
                        scan_pos = 0;
                        x1 = grp_means[0];
                        y1 = grp_means[1];
                        x2 = grp_means[2];
                        y2 = trimmed_mean();
                        ok = axis_close(x1, x2) && axis_close(y1, y2);
                        if (ok) begin
                            if (raw) begin
                                cur_x = 16'((x1 + x2) / 2);
                                cur_y = 16'((y1 + y2) / 2);
                            end else begin
                                cur_x = to_screen((x1 + x2) / 2, cfg_shadow.x_scale,
                                                  cfg_shadow.x_offset);
                                cur_y = to_screen((y1 + y2) / 2, cfg_shadow.y_scale,
                                                  cfg_shadow.y_offset);
                            end
                        end
                        // a new press latches its first position, even on a bad read
                        if (!held) begin
                            held    = 1'b1;
                            caught  = 1'b1;
                            first_x = cur_x;
                            first_y = cur_y;
                        end
                        pending_reports.push_back(snapshot(ok));
                    end
                end
            end
            MODE_PEN_UP: begin
                scan_pos = 0;
                if (held) begin
                    held = 1'b0;
                end else begin
                    first_x = '0;
                    first_y = '0;
                    cur_x   = IDLE_POS;
                    cur_y   = IDLE_POS;
                end
                pending_reports.push_back(snapshot(1'b0));
            end
            MODE_CLEAR: caught = 1'b0;
            default: ;
        endcase
    endtask

    // one request on the input stream; tvalid stays high for a following request
    task automatic send_item(input logic [1:0] mode, input logic [11:0] smp,
                             input logic raw);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, smp};
        s_axis_tuser  <= {raw, mode};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_request(mode, smp, raw);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic settle_block();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [18:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_X_SCALE:     cfg_shadow.x_scale     = data;
            REG_X_OFFSET:    cfg_shadow.x_offset    = data[15:0];
            REG_Y_SCALE:     cfg_shadow.y_scale     = data;
            REG_Y_OFFSET:    cfg_shadow.y_offset    = data[15:0];
            REG_AGREE_LIMIT: cfg_shadow.agree_limit = data[11:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int xs, input int xo, input int ys, input int yo,
                                  input int lim);
        settle_block();
        write_reg(REG_X_SCALE, xs[18:0]);
        write_reg(REG_X_OFFSET, {3'b0, xo[15:0]});
        write_reg(REG_Y_SCALE, ys[18:0]);
        write_reg(REG_Y_OFFSET, {3'b0, yo[15:0]});
        write_reg(REG_AGREE_LIMIT, {7'b0, lim[11:0]});
        i_cfg_valid <= 1'b0;
    endtask

    // one X/Y/X/Y scan around a random touch point, sometimes broken up
    task automatic send_scan();
        int cx, cy, dx, dy, sp, abort_at, clear_at, ctr, v, g;
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        sp = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 40);
        dx = ($urandom_range(4) == 0) ? 0 :
             ($urandom_range(3) == 0) ? $urandom_range(400) : $urandom_range(20);
        dy = ($urandom_range(4) == 0) ? 0 :
             ($urandom_range(3) == 0) ? $urandom_range(400) : $urandom_range(20);
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
        abort_at = ($urandom_range(11) == 0) ? $urandom_range(1, SCAN_LEN - 1) : SCAN_LEN;
        clear_at = ($urandom_range(9) == 0) ? $urandom_range(SCAN_LEN - 1) : SCAN_LEN;
        for (int i = 0; i < SCAN_LEN; i++) begin
            if (i == abort_at) begin
                send_item(MODE_PEN_UP, 12'($urandom), 1'($urandom));
                return;
            end
            if (i == clear_at) send_item(MODE_CLEAR, 12'($urandom), 1'($urandom));
            g   = i / SPR;
            ctr = (g % 2 == 0) ? cx : cy;
            if (g == 2) ctr += dx;
            if (g == 3) ctr += dy;
            // occasional outlier, which the trimming should drop
            if ($urandom_range(19) == 0) v = $urandom_range(4095);
            else v = ctr + int'($urandom_range(2 * sp)) - sp;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            send_item(MODE_SAMPLE, v[11:0], 1'($urandom));
        end
    endtask

    task automatic run_traffic(input int n);
        int start, r;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_scan();
                if ($urandom_range(1)) send_item(MODE_PEN_UP, 12'($urandom), 1'($urandom));
            end else if (r < 80) begin
                send_item(MODE_PEN_UP, 12'($urandom), 1'($urandom));
            end else if (r < 87) begin
                send_item(MODE_CLEAR, 12'($urandom), 1'($urandom));
            end else if (r < 90) begin
                send_item(MODE_UNUSED, 12'($urandom), 1'($urandom));
            end else if (r < 96) begin
                repeat ($urandom_range(1, SCAN_LEN - 1))
                    send_item(MODE_SAMPLE, 12'($urandom), 1'($urandom));
            end else begin
                hold_until_drained();
            end
        end
    endtask

    // pen-up from idle, ignored and clear requests, one raw scan with extreme samples
    task automatic test_directed_cases();
        logic [11:0] seq [SCAN_LEN];
        seq = '{12'd0, 12'd4095, 12'd2048, 12'd2049, 12'd2050,
                12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                12'd2047, 12'd2051, 12'd2048, 12'd2049, 12'd4095,
                12'd4095, 12'd4095, 12'd4094, 12'd4095, 12'd0};
        send_item(MODE_PEN_UP, 12'd0, 1'b0);
        send_item(MODE_UNUSED, 12'hFFF, 1'b1);
        send_item(MODE_CLEAR, 12'hFFF, 1'b0);
        for (int i = 0; i < SCAN_LEN; i++)
            send_item(MODE_SAMPLE, seq[i], (i == SCAN_LEN - 1) ? 1'b1 : 1'(i));
        send_item(MODE_CLEAR, 12'd0, 1'b1);
        send_item(MODE_PEN_UP, 12'hFFF, 1'b1);
    endtask

    // register extremes: unity, most negative, most positive, zero limit, zero scales and offsets
    task automatic test_register_extremes(input int n);
        apply_settings(65536, 0, 65536, 0, 50);
        run_traffic(n);
        apply_settings(-262144, -32768, -262144, -32768, 4095);
        run_traffic(n);
        apply_settings(262143, 32767, 262143, 32767, 1);
        run_traffic(n);
        apply_settings(-65536, 4095, 131072, -100, 0);
        run_traffic(n);
        apply_settings(0, 0, 0, 0, 50);
        run_traffic(n);
    endtask

    task automatic test_random_settings(input int n);
        for (int seg = 0; seg < 4; seg++) begin
            apply_settings(int'($urandom_range(524287)) - 262144,
                           int'($urandom_range(65535)) - 32768,
                           int'($urandom_range(524287)) - 262144,
                           int'($urandom_range(65535)) - 32768,
                           ($urandom_range(7) == 0) ? $urandom_range(4095)
                                                    : $urandom_range(300));
            run_traffic(n / 4);
        end
    endtask

    // a scan, then the sender holds off until its reports are back; then a pen-up and one more scan
    task automatic test_drain_pause();
        send_scan();
        hold_until_drained();
        send_item(MODE_PEN_UP, 12'($urandom), 1'($urandom));
        hold_until_drained();
        send_scan();
    endtask

    // receiver side: random tready, report check, stall counter
    always @(posedge i_clk) begin : result_check
        t_res got, want;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got.pos_x   = m_axis_tdata[15:0];
            got.pos_y   = m_axis_tdata[31:16];
            got.first_x = m_axis_tdata[47:32];
            got.first_y = m_axis_tdata[63:48];
            got.pressed = m_axis_tuser[0];
            got.caught  = m_axis_tuser[1];
            got.read_ok = m_axis_tuser[2];
            if (pending_reports.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("unexpected report: %s", fmt_res(got));
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN)
                        $display("report mismatch\n  want %s\n  got  %s",
                                 fmt_res(want), fmt_res(got));
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb_touch_sample_qualifier: errors");
        $finish;
    end

    initial begin
        cfg_shadow = '0;
        cfg_shadow.agree_limit = AGREE_RESET;
        scan_pos = 0;
        cur_x    = '0;
        cur_y    = '0;
        first_x  = '0;
        first_y  = '0;
        held     = 1'b0;
        caught   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 60;
        test_directed_cases();
        test_register_extremes(110);

        send_idle_pct = 60;
        recv_idle_pct = 24;
        test_random_settings(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_settings(600);
        test_drain_pause();

        settle_block();
        if (fault_count == 0 && pending_reports.size() == 0)
            $display("tb_touch_sample_qualifier: clean");
        else
            $display("tb_touch_sample_qualifier: errors");
        $finish;
    end

endmodule
